FILE: rtl/box_downsample_6x6_core_defines.svh
// Assertion macros shared by the box downsampler RTL.
`ifndef BOX_DOWNSAMPLE_6X6_CORE_DEFINES_SVH
`define BOX_DOWNSAMPLE_6X6_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BDS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BDS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bds_pkg.sv
// Package with constants, types and helpers of the box downsampler.
package bds_pkg;

    // Default limits handed to the top level parameters.
    localparam int DEF_MAX_OUT_WIDTH  = 128;
    localparam int DEF_MAX_OUT_HEIGHT = 1024;

    // Field and register widths.
    localparam int PIX_W        = 8;
    localparam int OUT_WIDTH_W  = 8;
    localparam int OUT_HEIGHT_W = 11;
    localparam int CFG_DATA_W   = 11;
    localparam int CFG_INDEX_W  = 1;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_HEIGHT = 1'd1;

    // Reset values of the configuration registers.
    localparam int RESET_OUT_WIDTH  = 128;
    localparam int RESET_OUT_HEIGHT = 64;

    // Accumulator widths and tile phase counting.
    localparam int SUM_W   = 14;
    localparam int RUN_W   = 11;
    localparam int PHASE_W = 3;
    localparam logic [PHASE_W-1:0] PHASE_ZERO = 3'd0;
    localparam logic [PHASE_W-1:0] LAST_PHASE = 3'd5;

    // Reciprocal scaling: average = (2 * sum * 910 + 2^15) >> 16.
    localparam int DIV_MUL   = 910;
    localparam int SCALE     = 2 * DIV_MUL;
    localparam int FRAC_BITS = 16;
    localparam int ROUND     = 1 << (FRAC_BITS - 1);
    localparam int PROD_W    = 25;
    localparam int QUOT_W    = PROD_W - FRAC_BITS;
    localparam int AVG_W     = 8;
    localparam logic [AVG_W-1:0] AVG_MAX = 8'hFF;

    // One finished tile on its way to the scaling stage.
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             row_end;
        logic             frame_end;
    } tile_res_t;

    // Last valid counter value for a programmed size: zero acts as one,
    // sizes above the limit act as the limit.
    function automatic int eff_last(input int value, input int max_value);
        int res;
        if (value == 0) begin
            res = 0;
        end else if (value > max_value) begin
            res = max_value - 1;
        end else begin
            res = value - 1;
        end
        return res;
    endfunction

endpackage

FILE: rtl/bds_tile_mem.sv
// Column partial-sum memory: one write port, one registered read port.
module bds_tile_mem #(
    parameter int DEPTH  = bds_pkg::DEF_MAX_OUT_WIDTH,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [ADDR_W-1:0]        wr_addr,
    input  logic [bds_pkg::SUM_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]        rd_addr,
    output logic [bds_pkg::SUM_W-1:0] rd_data
);

    logic [bds_pkg::SUM_W-1:0] mem [DEPTH];
    logic [bds_pkg::SUM_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/bds_avg.sv
// Tile average stage: holds a finished tile sum, scales it and drives the result word.
module bds_avg (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    input  bds_pkg::tile_res_t        in_res,
    output logic                      in_ready,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [bds_pkg::AVG_W-1:0] m_average,
    output logic                      m_row_end,
    output logic                      m_frame_end
);

    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    bds_pkg::tile_res_t         s1_res_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [bds_pkg::AVG_W-1:0]  avg_reg;
    logic                       row_end_reg;
    logic                       frame_end_reg;
    logic                       out_free;
    logic                       s1_move;
    logic [bds_pkg::PROD_W-1:0] prod;
    logic [bds_pkg::QUOT_W-1:0] quot;
    logic [bds_pkg::AVG_W-1:0]  avg_clamped;

    // Handshake between the holding stage and the output word.
    assign out_free = !out_valid_reg || m_ready;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (in_valid) begin
            s1_valid_next = 1'b1;
        end else if (s1_move) begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_move) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Multiply by the reciprocal of 36 with rounding, then clamp.
    assign prod = bds_pkg::PROD_W'(s1_res_reg.sum) * bds_pkg::PROD_W'(bds_pkg::SCALE)
                + bds_pkg::PROD_W'(bds_pkg::ROUND);
    assign quot = prod[bds_pkg::PROD_W-1:bds_pkg::FRAC_BITS];
    assign avg_clamped = (quot > bds_pkg::QUOT_W'(bds_pkg::AVG_MAX)) ?
                         bds_pkg::AVG_MAX : quot[bds_pkg::AVG_W-1:0];

    // Valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (in_valid) begin
            s1_res_reg <= in_res;
        end
        if (s1_move) begin
            avg_reg       <= avg_clamped;
            row_end_reg   <= s1_res_reg.row_end;
            frame_end_reg <= s1_res_reg.frame_end;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_average   = avg_reg;
    assign m_row_end   = row_end_reg;
    assign m_frame_end = frame_end_reg;

endmodule

FILE: rtl/box_downsample_6x6_core.sv
// Top level of the 6x6 box-filter downsampler for 8-bit gray pixels.
//
// Takes one pixel per clock in raster order and returns one rounded 6x6 tile
// average for every 36 pixels, with row and frame end flags. Each run of six
// pixels is summed in a register; the run sum is then written to, or added
// to, the entry of a one-port-read, one-port-write memory that holds one
// 14-bit partial sum per output column. The memory is read every cycle at the
// current output column, so its data is ready long before the column's sixth
// pixel arrives. A tile sum is registered, then scaled into the output
// register. Input is stalled only when a result word waits on the output and
// a second finished tile is already held. The column memory needs no clearing
// after reset: every entry is written in the first row of a band before it is
// read. Program out_width and out_height only while no pixel is in flight.
`include "box_downsample_6x6_core_defines.svh"

module box_downsample_6x6_core #(
    parameter int MAX_OUT_WIDTH  = bds_pkg::DEF_MAX_OUT_WIDTH,
    parameter int MAX_OUT_HEIGHT = bds_pkg::DEF_MAX_OUT_HEIGHT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wen,
    input  logic [bds_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bds_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [bds_pkg::PIX_W-1:0]       s_pixel,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [bds_pkg::AVG_W-1:0]       m_average,
    output logic                           m_row_end,
    output logic                           m_frame_end
);

    localparam int COL_W = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
    localparam int ROW_W = (MAX_OUT_HEIGHT > 1) ? $clog2(MAX_OUT_HEIGHT) : 1;
    localparam logic [COL_W-1:0] W_LAST_RESET =
        COL_W'(bds_pkg::eff_last(bds_pkg::RESET_OUT_WIDTH, MAX_OUT_WIDTH));
    localparam logic [ROW_W-1:0] H_LAST_RESET =
        ROW_W'(bds_pkg::eff_last(bds_pkg::RESET_OUT_HEIGHT, MAX_OUT_HEIGHT));

    logic [COL_W-1:0]            w_last_reg;
    logic [ROW_W-1:0]            h_last_reg;
    logic [bds_pkg::RUN_W-1:0]   run_sum_reg;
    logic [bds_pkg::RUN_W-1:0]   run_sum_next;
    logic [bds_pkg::PHASE_W-1:0] col_phase_reg;
    logic [bds_pkg::PHASE_W-1:0] col_phase_next;
    logic [COL_W-1:0]            out_col_reg;
    logic [COL_W-1:0]            out_col_next;
    logic [bds_pkg::PHASE_W-1:0] row_phase_reg;
    logic [bds_pkg::PHASE_W-1:0] row_phase_next;
    logic [ROW_W-1:0]            out_row_reg;
    logic [ROW_W-1:0]            out_row_next;

    logic                        accept;
    logic                        tile_end;
    logic                        band_end;
    logic                        last_col;
    logic                        last_row;
    logic                        emit;
    logic                        mem_wr_en;
    logic [bds_pkg::RUN_W-1:0]   run_sum_new;
    logic [bds_pkg::SUM_W-1:0]   col_sum;
    logic [bds_pkg::SUM_W-1:0]   mem_rd_data;
    bds_pkg::tile_res_t          tile_res;

    // Configuration registers keep the last counter value of each size.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_last_reg <= W_LAST_RESET;
            h_last_reg <= H_LAST_RESET;
        end else if (cfg_wen) begin
            case (cfg_index)
                bds_pkg::REG_OUT_WIDTH: begin
                    w_last_reg <= COL_W'(bds_pkg::eff_last(
                        int'(cfg_wdata[bds_pkg::OUT_WIDTH_W-1:0]), MAX_OUT_WIDTH));
                end
                bds_pkg::REG_OUT_HEIGHT: begin
                    h_last_reg <= ROW_W'(bds_pkg::eff_last(
                        int'(cfg_wdata[bds_pkg::OUT_HEIGHT_W-1:0]), MAX_OUT_HEIGHT));
                end
                default: begin
                end
            endcase
        end
    end

    // Pixel accumulation and tile sum read-modify-write.
    assign accept   = s_valid && s_ready;
    assign tile_end = col_phase_reg >= bds_pkg::LAST_PHASE;
    assign band_end = row_phase_reg >= bds_pkg::LAST_PHASE;
    assign last_col = out_col_reg >= w_last_reg;
    assign last_row = out_row_reg >= h_last_reg;

    assign run_sum_new = (col_phase_reg == bds_pkg::PHASE_ZERO) ?
                         bds_pkg::RUN_W'(s_pixel) :
                         run_sum_reg + bds_pkg::RUN_W'(s_pixel);
    assign col_sum = (row_phase_reg == bds_pkg::PHASE_ZERO) ?
                     bds_pkg::SUM_W'(run_sum_new) :
                     mem_rd_data + bds_pkg::SUM_W'(run_sum_new);

    assign emit      = accept && tile_end && band_end;
    assign mem_wr_en = accept && tile_end && !band_end;

    assign tile_res.sum       = col_sum;
    assign tile_res.row_end   = last_col;
    assign tile_res.frame_end = last_col && last_row;

    // Counter advance on each accepted pixel.
    always_comb begin
        run_sum_next   = run_sum_reg;
        col_phase_next = col_phase_reg;
        out_col_next   = out_col_reg;
        row_phase_next = row_phase_reg;
        out_row_next   = out_row_reg;
        if (accept) begin
            run_sum_next = run_sum_new;
            if (tile_end) begin
                col_phase_next = bds_pkg::PHASE_ZERO;
                if (last_col) begin
                    out_col_next = '0;
                    if (band_end) begin
                        row_phase_next = bds_pkg::PHASE_ZERO;
                        out_row_next   = last_row ? '0 : out_row_reg + 1'b1;
                    end else begin
                        row_phase_next = row_phase_reg + 1'b1;
                    end
                end else begin
                    out_col_next = out_col_reg + 1'b1;
                end
            end else begin
                col_phase_next = col_phase_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_sum_reg   <= '0;
            col_phase_reg <= bds_pkg::PHASE_ZERO;
            out_col_reg   <= '0;
            row_phase_reg <= bds_pkg::PHASE_ZERO;
            out_row_reg   <= '0;
        end else begin
            run_sum_reg   <= run_sum_next;
            col_phase_reg <= col_phase_next;
            out_col_reg   <= out_col_next;
            row_phase_reg <= row_phase_next;
            out_row_reg   <= out_row_next;
        end
    end

    // Column partial sums.
    bds_tile_mem #(
        .DEPTH  (MAX_OUT_WIDTH),
        .ADDR_W (COL_W)
    ) u_tile_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (out_col_reg),
        .wr_data (col_sum),
        .rd_addr (out_col_reg),
        .rd_data (mem_rd_data)
    );

    // Scaling and output word.
    bds_avg u_avg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (emit),
        .in_res      (tile_res),
        .in_ready    (s_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_average   (m_average),
        .m_row_end   (m_row_end),
        .m_frame_end (m_frame_end)
    );

    // Input stalls only behind a held result word.
    `BDS_ASSERT_SAME(a_stall_cause, !s_ready, m_valid && !m_ready, "input stalled without backpressure")
    // A frame end always closes a row.
    `BDS_ASSERT_SAME(a_frame_row, m_valid, m_row_end || !m_frame_end, "frame end without row end")
    // Phase counters never pass the last tile phase.
    `BDS_ASSERT_SAME(a_phase_range, 1'b1, (col_phase_reg <= bds_pkg::LAST_PHASE) && (row_phase_reg <= bds_pkg::LAST_PHASE), "phase counter out of range")
    // The sixth pixel of a run restarts the column phase.
    `BDS_ASSERT_NEXT(a_run_wrap, accept && tile_end, col_phase_reg == bds_pkg::PHASE_ZERO, "column phase did not wrap")

endmodule

FILE: bench/tb_box_downsample_6x6_core.sv
// Self-checking testbench for the 6x6 box-filter downsampler core.
`timescale 1ns / 100ps

module tb_box_downsample_6x6_core;

    // Sizes as the block clamps them, plus bench timing limits.
    localparam int W_MAX         = bds_pkg::DEF_MAX_OUT_WIDTH;
    localparam int H_MAX         = bds_pkg::DEF_MAX_OUT_HEIGHT;
    localparam int TILE_LAST     = 5;
    localparam int TILE_RECIP    = 910;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 2000;
    localparam int LONG_HOLD     = 300;

    // One tile average as it should leave the block.
    typedef struct {
        logic [bds_pkg::AVG_W-1:0] average;
        logic                      row_end;
        logic                      frame_end;
    } tile_avg_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            cfg_wen = 1'b0;
    logic [bds_pkg::CFG_INDEX_W-1:0] cfg_index = bds_pkg::REG_OUT_WIDTH;
    logic [bds_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic [bds_pkg::PIX_W-1:0]       s_pixel = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic [bds_pkg::AVG_W-1:0]       m_average;
    logic                            m_row_end;
    logic                            m_frame_end;

    // Predicted state of the downsampler.
    logic [7:0]  cfg_out_width = 8'd128;
    logic [10:0] cfg_out_height = 11'd64;
    logic [13:0] tile_sums [W_MAX];
    logic [10:0] run_sum = '0;
    logic [2:0]  col_phase = '0;
    logic [6:0]  out_col = '0;
    logic [2:0]  row_phase = '0;
    logic [9:0]  out_row = '0;

    tile_avg_t expected_tiles [$];

    int error_count = 0;
    int pixels_sent = 0;
    int tiles_checked = 0;
    int reg_writes = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    box_downsample_6x6_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wen     (cfg_wen),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pixel     (s_pixel),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_average   (m_average),
        .m_row_end   (m_row_end),
        .m_frame_end (m_frame_end)
    );

    always #4 aclk = ~aclk;

    // A programmed size of zero means one; anything past the limit means the limit.
    function automatic int clamp_size(input int value, input int max_value);
        if (value == 0) begin
            return 1;
        end
        return (value > max_value) ? max_value : value;
    endfunction

    // Advance the predicted state by one pixel and queue any tile average it completes.
    function automatic void predict_pixel(input logic [7:0] pix);
        int unsigned w_eff;
        int unsigned h_eff;
        int unsigned scaled;
        logic [13:0] sum;
        bit          last_col;
        bit          last_row;
        tile_avg_t   res;
        w_eff = clamp_size(cfg_out_width, W_MAX);
        h_eff = clamp_size(cfg_out_height, H_MAX);
        if (col_phase == 0) begin
            run_sum = pix;
        end else begin
            run_sum = run_sum + pix;
        end
        if (col_phase >= TILE_LAST) begin
            if (row_phase == 0) begin
                sum = run_sum;
            end else begin
                sum = tile_sums[out_col] + run_sum;
            end
            last_col = (out_col >= w_eff - 1);
            last_row = (out_row >= h_eff - 1);
            if (row_phase >= TILE_LAST) begin
                scaled = (2 * sum * TILE_RECIP + 32768) >> 16;
                if (scaled > 255) begin
                    scaled = 255;
                end
                res.average   = scaled[7:0];
                res.row_end   = last_col;
                res.frame_end = last_col && last_row;
                expected_tiles.push_back(res);
            end else begin
                tile_sums[out_col] = sum;
            end
            col_phase = 0;
            if (last_col) begin
                out_col = 0;
                if (row_phase >= TILE_LAST) begin
                    row_phase = 0;
                    out_row = last_row ? 10'd0 : out_row + 10'd1;
                end else begin
                    row_phase = row_phase + 3'd1;
                end
            end else begin
                out_col = out_col + 7'd1;
            end
        end else begin
            col_phase = col_phase + 3'd1;
        end
    endfunction

    function automatic bit at_band_start();
        return (col_phase == 0) && (out_col == 0) && (row_phase == 0);
    endfunction

    // Pixel content for one band: uniform noise, flat white, flat black or near black.
    function automatic logic [7:0] pick_pixel(input int style);
        case (style)
            2: return 8'd255;
            3: return 8'd0;
            4: return 8'($urandom_range(0, 3));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // Offer one pixel word, with random idle cycles ahead of it, and wait for acceptance.
    task automatic send_pixel(input logic [7:0] pix);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_pixel <= pix;
        do @(posedge aclk); while (!s_ready);
        predict_pixel(pix);
        pixels_sent++;
    endtask

    task automatic finish_band(input int style);
        while (!at_band_start()) begin
            send_pixel(pick_pixel(style));
        end
    endtask

    task automatic send_bands(input int count);
        int style;
        repeat (count) begin
            style = $urandom_range(0, 5);
            send_pixel(pick_pixel(style));
            finish_band(style);
        end
    endtask

    // Stop offering and wait until every predicted average has come out.
    task automatic drain_results();
        if (s_valid) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        while (expected_tiles.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [bds_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [bds_pkg::CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_wen <= 1'b0;
        if (idx == bds_pkg::REG_OUT_WIDTH) begin
            cfg_out_width = data[7:0];
        end else begin
            cfg_out_height = data;
        end
        reg_writes++;
    endtask

    // Flat white, flat black, a single bright pixel and a dim tile, each as a 1x1 frame.
    task automatic test_tile_extremes();
        drain_results();
        write_reg(bds_pkg::REG_OUT_WIDTH, 11'd1);
        write_reg(bds_pkg::REG_OUT_HEIGHT, 11'd1);
        repeat (36) send_pixel(8'd255);
        repeat (36) send_pixel(8'd0);
        repeat (35) send_pixel(8'd0);
        send_pixel(8'd255);
        repeat (36) send_pixel(8'd1);
    endtask

    // Zero and oversized registers and tall frames.
    task automatic test_size_clamps();
        drain_results();
        write_reg(bds_pkg::REG_OUT_WIDTH, 11'd0);
        write_reg(bds_pkg::REG_OUT_HEIGHT, 11'd0);
        send_bands(1);
        // A few tiles of a first band row at an oversized width, then a width
        // below the current column, which closes that row at the next tile.
        drain_results();
        write_reg(bds_pkg::REG_OUT_WIDTH, 11'd255);
        repeat (18) send_pixel(pick_pixel(0));
        drain_results();
        write_reg(bds_pkg::REG_OUT_WIDTH, 11'd2);
        finish_band(0);
        drain_results();
        write_reg(bds_pkg::REG_OUT_WIDTH, 11'd1);
        write_reg(bds_pkg::REG_OUT_HEIGHT, 11'd2047);
        send_bands(1);
        drain_results();
        write_reg(bds_pkg::REG_OUT_HEIGHT, 11'd1024);
        send_bands(1);
        drain_results();
        write_reg(bds_pkg::REG_OUT_HEIGHT, 11'd1500);
        send_bands(1);
    endtask

    // Shrink the width mid-band past the current column, and the height past the current row.
    task automatic test_midframe_resize();
        drain_results();
        write_reg(bds_pkg::REG_OUT_WIDTH, 11'd8);
        write_reg(bds_pkg::REG_OUT_HEIGHT, 11'd4);
        repeat (174) send_pixel(pick_pixel(0));
        drain_results();
        write_reg(bds_pkg::REG_OUT_WIDTH, 11'd3);
        finish_band(0);
        drain_results();
        write_reg(bds_pkg::REG_OUT_WIDTH, 11'd1);
        send_bands(3);
        drain_results();
        write_reg(bds_pkg::REG_OUT_HEIGHT, 11'd2);
        send_bands(2);
    endtask

    // Receiver holds off long enough to fill the block; later the sender pauses for a drain.
    task automatic test_backpressure();
        drain_results();
        write_reg(bds_pkg::REG_OUT_WIDTH, 11'd1);
        write_reg(bds_pkg::REG_OUT_HEIGHT, 11'd3);
        hold_left = LONG_HOLD;
        repeat (150) send_pixel(pick_pixel(0));
        drain_results();
        repeat (50) send_pixel(pick_pixel(0));
        finish_band(0);
    endtask

    task automatic random_sizes();
        int          sel;
        int          r;
        logic [2:0]  junk;
        logic [7:0]  w_byte;
        logic [10:0] h_val;
        sel = $urandom_range(0, 2);
        if (sel != 1) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                w_byte = 8'($urandom_range(1, 6));
            end else if (r < 90) begin
                w_byte = 8'($urandom_range(7, 16));
            end else begin
                w_byte = 8'd0;
            end
            // The upper data bits do not belong to the width register.
            junk = 3'($urandom_range(0, 7));
            write_reg(bds_pkg::REG_OUT_WIDTH, {junk, w_byte});
        end
        if (sel != 0) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                h_val = 11'($urandom_range(0, 4));
            end else if (r < 85) begin
                h_val = 11'($urandom_range(5, 12));
            end else begin
                h_val = 11'($urandom_range(0, 2047));
            end
            write_reg(bds_pkg::REG_OUT_HEIGHT, h_val);
        end
    endtask

    // Whole bands of random content under random sizes, at one idle mix.
    task automatic test_random_frames(input int idle_in, input int stall_out, input int items);
        int start;
        send_idle_pct  = idle_in;
        recv_stall_pct = stall_out;
        start = pixels_sent;
        while (pixels_sent - start < items) begin
            drain_results();
            random_sizes();
            send_bands(1);
        end
    endtask

    // Result side: random stalls, or a counted hold-off when one is requested.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Compare every accepted result word with the oldest prediction.
    always @(posedge aclk) begin : check_results
        tile_avg_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_tiles.size() == 0) begin
                report_mismatch($sformatf("unexpected average %0d", m_average));
            end else begin
                want = expected_tiles.pop_front();
                tiles_checked++;
                if (m_average !== want.average) begin
                    report_mismatch($sformatf("average %0d, want %0d", m_average, want.average));
                end
                if (m_row_end !== want.row_end) begin
                    report_mismatch($sformatf("row_end %b, want %b", m_row_end, want.row_end));
                end
                if (m_frame_end !== want.frame_end) begin
                    report_mismatch($sformatf("frame_end %b, want %b",
                                              m_frame_end, want.frame_end));
                end
            end
        end
    end

    // Give up when no word moves on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_box_downsample_6x6_core: no word moved in %0d cycles, %0d pending",
                     STALL_LIMIT, expected_tiles.size());
            $display("tb_box_downsample_6x6_core: done, errors");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_tile_extremes();
        test_size_clamps();
        test_midframe_resize();
        test_backpressure();
        test_random_frames(0, 0, 60);
        test_random_frames(56, 0, 60);
        test_random_frames(0, 56, 60);
        test_random_frames(17, 17, 60);
        drain_results();

        $display("tb_box_downsample_6x6_core: %0d pixels in, %0d averages checked, %0d reg writes",
                 pixels_sent, tiles_checked, reg_writes);
        $display("  size clamps, mid-band resizing, long output hold-off, four idle mixes");
        if (error_count == 0) begin
            $display("tb_box_downsample_6x6_core: done, clean");
        end else begin
            $display("tb_box_downsample_6x6_core: done, errors");
        end
        $finish;
    end

endmodule
